### rtl/core/cjd_pkg.sv
// Shared widths, constants, lookup tables and flow-control types for the calendar converter.
package cjd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DomW   = 5;
  localparam int unsigned JdW    = 23;
  localparam int unsigned WdW    = 3;
  localparam int unsigned OrdW   = 9;

  localparam int unsigned NumStages = 19;

  localparam logic OpDateToJd = 1'b0;
  localparam logic OpJdToDate = 1'b1;

  localparam logic [JdW-1:0]   JdMin   = 23'd1721426;
  localparam logic [JdW-1:0]   JdMax   = 23'd5373484;
  localparam logic [YearW-1:0] YearMax = 14'd9999;

  typedef struct packed {
    logic [NumStages-1:0] vld;
    logic [NumStages-1:0] en;
  } cjd_flow_t;

  // floor(367 * (m - 2 - 12a) / 12), with a = -1 for January and February
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] month);
    logic [8:0] res;
    case (month)
      4'd1:    res = 9'd336;
      4'd2:    res = 9'd367;
      4'd3:    res = 9'd30;
      4'd4:    res = 9'd61;
      4'd5:    res = 9'd91;
      4'd6:    res = 9'd122;
      4'd7:    res = 9'd152;
      4'd8:    res = 9'd183;
      4'd9:    res = 9'd214;
      4'd10:   res = 9'd244;
      4'd11:   res = 9'd275;
      4'd12:   res = 9'd305;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // floor(2447 * j / 80)
  function automatic logic [8:0] dom_offset(input logic [3:0] j);
    logic [8:0] res;
    case (j)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd30;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd91;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd152;
      4'd6:    res = 9'd183;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd244;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd305;
      4'd11:   res = 9'd336;
      4'd12:   res = 9'd367;
      4'd13:   res = 9'd397;
      4'd14:   res = 9'd428;
      4'd15:   res = 9'd458;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

### rtl/core/cjd_flow_ctrl.sv
// Per-stage valid bits and load enables for the converter pipeline.
module cjd_flow_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_stall_i,
  output cjd_pkg::cjd_flow_t flow_o
);

  localparam int unsigned N = cjd_pkg::NumStages;

  logic [N-1:0] vld_q;
  logic [N-1:0] en;

  // a stage loads when it is empty or everything downstream of it moves
  for (genvar k = 0; k < N; k++) begin : g_en
    assign en[k] = !out_stall_i || !(&vld_q[N-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < N; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign flow_o.vld = vld_q;
  assign flow_o.en  = en;

endmodule

### rtl/core/calendar_julian_day_converter_unit.sv
// Top level: pipelined Gregorian date / Julian day number converter.
// Depth: 19 register stages, each holding about one constant multiply.
// Throughput: one transaction per cycle, except while an output stall holds a full pipeline.
// Stalls back up stage by stage, so bubbles are squeezed out and nothing is lost.
// Reset clears all stage valid bits at once; datapath registers are not reset.
module calendar_julian_day_converter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [cjd_pkg::YearW-1:0]   in_year_i,
  input  logic [cjd_pkg::MonthW-1:0]  in_month_i,
  input  logic [cjd_pkg::DomW-1:0]    in_dom_i,
  input  logic [cjd_pkg::JdW-1:0]     in_day_number_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cjd_pkg::JdW-1:0]     out_day_number_o,
  output logic [cjd_pkg::YearW-1:0]   out_year_o,
  output logic [cjd_pkg::MonthW-1:0]  out_month_o,
  output logic [cjd_pkg::DomW-1:0]    out_dom_o,
  output logic [cjd_pkg::WdW-1:0]     weekday_number_o,
  output logic [cjd_pkg::OrdW-1:0]    ordinal_day_o,
  output logic                        status_o
);

  localparam int unsigned N  = cjd_pkg::NumStages;
  localparam int unsigned JW = cjd_pkg::JdW;
  localparam int unsigned YW = cjd_pkg::YearW;

  cjd_pkg::cjd_flow_t flow;
  logic [N-1:0]       en;

  cjd_flow_ctrl u_flow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .flow_o     (flow)
  );

  assign en          = flow.en;
  assign in_stall_o  = !en[0];
  assign out_valid_o = flow.vld[N-1];

  // ---------------------------------------------------------------- registers
  logic                  bad_q   [0:N-2];
  logic                  op_q    [0:1];
  logic [JW-1:0]         jdin_q  [0:1];
  logic [8:0]            t2_q    [0:1];
  logic [cjd_pkg::DomW-1:0] dom_q [0:1];
  logic [YW-1:0]         yp_q;
  logic [YW-1:0]         xc_q;
  logic [24:0]           p1_q;
  logic [26:0]           p2_q;
  logic [JW-1:0]         jd_q    [2:N-2];
  logic [24:0]           x_q     [3:4];
  logic [5:0]            wsum_q;
  logic [cjd_pkg::WdW-1:0] wd_q  [4:N-2];
  logic [7:0]            qn_q    [4:5];
  logic [24:0]           rn_q;
  logic [7:0]            n_q     [6:14];
  logic [15:0]           l2_q    [6:10];
  logic [27:0]           xi_q    [7:8];
  logic [7:0]            qi_q    [8:9];
  logic [27:0]           ri_q;
  logic [7:0]            i_q     [10:14];
  logic [9:0]            l3_q    [11:14];
  logic [16:0]           xj_q    [12:13];
  logic [5:0]            qj_q;
  logic [3:0]            j_q;
  logic [YW-1:0]         y_q     [15:17];
  logic [cjd_pkg::MonthW-1:0] m_q [15:17];
  logic [cjd_pkg::DomW-1:0]   d_q [15:17];
  logic [24:0]           p1b_q;
  logic [26:0]           p2b_q;
  logic [JW-1:0]         jan1_q;

  logic [JW-1:0]              out_jd_q;
  logic [YW-1:0]              out_year_q;
  logic [cjd_pkg::MonthW-1:0] out_month_q;
  logic [cjd_pkg::DomW-1:0]   out_dom_q;
  logic [cjd_pkg::WdW-1:0]    out_wd_q;
  logic [cjd_pkg::OrdW-1:0]   out_ord_q;
  logic                       out_status_q;

  // ---------------------------------------------------------- next values
  logic                     mon_le2;
  logic                     bad_d;
  logic [YW-1:0]            yp_d, xc_d;
  logic [24:0]              p1_d;
  logic [26:0]              p2_d;
  logic [7:0]               cent;
  logic [9:0]               cent3;
  logic [JW-1:0]            jd_date, jd_d;
  logic [24:0]              x_d;
  logic [23:0]              jd_inc;
  logic [5:0]               wsum_d;
  logic [3:0]               wfold1;
  logic [2:0]               wfold2;
  logic [cjd_pkg::WdW-1:0]  wd_d;
  logic [32:0]              en_prod;
  logic [24:0]              rn_d;
  logic                     rn_ge;
  logic [24:0]              rn_fix;
  logic [7:0]               n_d;
  logic [27:0]              xi_d;
  logic [35:0]              ei_prod;
  logic [27:0]              ri_d;
  logic [7:0]               i_d;
  logic [18:0]              ci_prod;
  logic [9:0]               l3_d;
  logic [16:0]              xj_d;
  logic [22:0]              ej_prod;
  logic [16:0]              rj;
  logic [5:0]               jfix;
  logic                     l4;
  logic [YW-1:0]            y_d;
  logic [cjd_pkg::MonthW-1:0] m_d;
  logic [cjd_pkg::DomW-1:0] d_d;
  logic [24:0]              p1b_d;
  logic [26:0]              p2b_d;
  logic [9:0]               cent3b;
  logic [JW-1:0]            jan1_d;
  logic [cjd_pkg::OrdW-1:0] ord_d;

  always_comb begin
    // stage 0: range check and year terms
    mon_le2 = in_month_i <= 4'd2;
    if (opcode_i == cjd_pkg::OpJdToDate) begin
      bad_d = (in_day_number_i < cjd_pkg::JdMin) || (in_day_number_i > cjd_pkg::JdMax);
    end else begin
      bad_d = (in_year_i == '0) || (in_year_i > cjd_pkg::YearMax) ||
              (in_month_i == '0) || (in_month_i > 4'd12) || (in_dom_i == '0);
    end
    yp_d = in_year_i + 14'd4800 - YW'(mon_le2);
    xc_d = in_year_i + 14'd4900 - YW'(mon_le2);

    // stage 1: year products; floor(x / 100) as (x * 5243) >> 19
    p1_d = 25'(yp_q) * 25'd1461;
    p2_d = 27'(xc_q) * 27'd5243;

    // stage 2: day number of the date, or pass the input through
    cent    = p2_q[26:19];
    cent3   = 10'(cent) * 10'd3;
    jd_date = p1_q[24:2] + JW'(t2_q[1]) + JW'(dom_q[1]) - JW'(cent3[9:2]) - 23'd32075;
    jd_d    = (op_q[1] == cjd_pkg::OpJdToDate) ? jdin_q[1] : jd_date;

    // stage 3: 4 * (jd + 68569); weekday = (jd + 1) mod 7 by octal digit sum
    x_d    = {jd_q[2] + 23'd68569, 2'b00};
    jd_inc = 24'(jd_q[2]) + 24'd1;
    wsum_d = '0;
    for (int k = 0; k < 8; k++) begin
      wsum_d = wsum_d + 6'(jd_inc[3*k +: 3]);
    end

    // stage 4: quotient estimate by 146097, low by at most one; fold the weekday digit sum mod 7
    en_prod = 33'(x_q[3]) * 33'd229;
    wfold1  = 4'(wsum_q[5:3]) + 4'(wsum_q[2:0]);
    wfold2  = 3'(wfold1[3]) + wfold1[2:0];
    wd_d    = (wfold2 == 3'd7) ? 3'd0 : wfold2;

    // stage 5: remainder of the estimate
    rn_d = x_q[4] - 25'(qn_q[4]) * 25'd146097;

    // stage 6: correct quotient; the leftover day count is remainder / 4
    rn_ge  = rn_q >= 25'd146097;
    rn_fix = rn_ge ? rn_q - 25'd146097 : rn_q;
    n_d    = rn_ge ? qn_q[5] + 8'd1 : qn_q[5];

    // stage 7
    xi_d = (28'(l2_q[6]) + 28'd1) * 28'd4000;

    // stage 8: quotient estimate by 1461001
    ei_prod = 36'(xi_q[7]) * 36'd183;

    // stage 9
    ri_d = xi_q[8] - 28'(qi_q[8]) * 28'd1461001;

    // stage 10
    i_d = (ri_q >= 28'd1461001) ? qi_q[9] + 8'd1 : qi_q[9];

    // stage 11
    ci_prod = 19'(i_q[10]) * 19'd1461;
    l3_d    = 10'(19'(l2_q[10]) + 19'd31 - (ci_prod >> 2));

    // stage 12
    xj_d = 17'(l3_q[11]) * 17'd80;

    // stage 13: quotient estimate by 2447
    ej_prod = 23'(xj_q[12]) * 23'd53;

    // stage 14: correct month index
    rj   = xj_q[13] - 17'(qj_q) * 17'd2447;
    jfix = (rj >= 17'd2447) ? qj_q + 6'd1 : qj_q;

    // stage 15: assemble the date
    l4  = j_q >= 4'd11;
    d_d = 5'(l3_q[14] - 10'(cjd_pkg::dom_offset(j_q)));
    m_d = j_q + 4'd2 - (l4 ? 4'd12 : 4'd0);
    y_d = (14'(n_q[14]) - 14'd49) * 14'd100 + 14'(i_q[14]) + YW'(l4);

    // stage 16: January 1 terms of that year
    p1b_d = 25'(y_q[15] + 14'd4799) * 25'd1461;
    p2b_d = 27'(y_q[15] + 14'd4899) * 27'd5243;

    // stage 17: day number of January 1 (month term for January is 336)
    cent3b = 10'(p2b_q[26:19]) * 10'd3;
    jan1_d = p1b_q[24:2] + 23'd337 - JW'(cent3b[9:2]) - 23'd32075;

    // stage 18
    ord_d = 9'(jd_q[17] - jan1_q + 23'd1);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      bad_q[0]  <= bad_d;
      op_q[0]   <= opcode_i;
      jdin_q[0] <= in_day_number_i;
      t2_q[0]   <= cjd_pkg::month_offset(in_month_i);
      dom_q[0]  <= in_dom_i;
      yp_q      <= yp_d;
      xc_q      <= xc_d;
    end
    for (int k = 1; k <= N - 2; k++) begin
      if (en[k]) begin
        bad_q[k] <= bad_q[k-1];
      end
    end
    if (en[1]) begin
      op_q[1]   <= op_q[0];
      jdin_q[1] <= jdin_q[0];
      t2_q[1]   <= t2_q[0];
      dom_q[1]  <= dom_q[0];
      p1_q      <= p1_d;
      p2_q      <= p2_d;
    end
    if (en[2]) begin
      jd_q[2] <= jd_d;
    end
    for (int k = 3; k <= N - 2; k++) begin
      if (en[k]) begin
        jd_q[k] <= jd_q[k-1];
      end
    end
    if (en[3]) begin
      x_q[3] <= x_d;
      wsum_q <= wsum_d;
    end
    if (en[4]) begin
      x_q[4]  <= x_q[3];
      qn_q[4] <= en_prod[32:25];
      wd_q[4] <= wd_d;
    end
    for (int k = 5; k <= N - 2; k++) begin
      if (en[k]) begin
        wd_q[k] <= wd_q[k-1];
      end
    end
    if (en[5]) begin
      rn_q    <= rn_d;
      qn_q[5] <= qn_q[4];
    end
    if (en[6]) begin
      n_q[6]  <= n_d;
      l2_q[6] <= rn_fix[17:2];
    end
    for (int k = 7; k <= 14; k++) begin
      if (en[k]) begin
        n_q[k] <= n_q[k-1];
      end
    end
    for (int k = 7; k <= 10; k++) begin
      if (en[k]) begin
        l2_q[k] <= l2_q[k-1];
      end
    end
    if (en[7]) begin
      xi_q[7] <= xi_d;
    end
    if (en[8]) begin
      xi_q[8] <= xi_q[7];
      qi_q[8] <= ei_prod[35:28];
    end
    if (en[9]) begin
      ri_q    <= ri_d;
      qi_q[9] <= qi_q[8];
    end
    if (en[10]) begin
      i_q[10] <= i_d;
    end
    for (int k = 11; k <= 14; k++) begin
      if (en[k]) begin
        i_q[k] <= i_q[k-1];
      end
    end
    if (en[11]) begin
      l3_q[11] <= l3_d;
    end
    for (int k = 12; k <= 14; k++) begin
      if (en[k]) begin
        l3_q[k] <= l3_q[k-1];
      end
    end
    if (en[12]) begin
      xj_q[12] <= xj_d;
    end
    if (en[13]) begin
      xj_q[13] <= xj_q[12];
      qj_q     <= ej_prod[22:17];
    end
    if (en[14]) begin
      j_q <= jfix[3:0];
    end
    if (en[15]) begin
      y_q[15] <= y_d;
      m_q[15] <= m_d;
      d_q[15] <= d_d;
    end
    for (int k = 16; k <= 17; k++) begin
      if (en[k]) begin
        y_q[k] <= y_q[k-1];
        m_q[k] <= m_q[k-1];
        d_q[k] <= d_q[k-1];
      end
    end
    if (en[16]) begin
      p1b_q <= p1b_d;
      p2b_q <= p2b_d;
    end
    if (en[17]) begin
      jan1_q <= jan1_d;
    end
    // zero every result field of a rejected transaction; status carries the reject flag
    if (en[N-1]) begin
      out_status_q <= bad_q[N-2];
      out_jd_q     <= bad_q[N-2] ? '0 : jd_q[N-2];
      out_year_q   <= bad_q[N-2] ? '0 : y_q[17];
      out_month_q  <= bad_q[N-2] ? '0 : m_q[17];
      out_dom_q    <= bad_q[N-2] ? '0 : d_q[17];
      out_wd_q     <= bad_q[N-2] ? '0 : wd_q[N-2];
      out_ord_q    <= bad_q[N-2] ? '0 : ord_d;
    end
  end

  assign out_day_number_o = out_jd_q;
  assign out_year_o       = out_year_q;
  assign out_month_o      = out_month_q;
  assign out_dom_o        = out_dom_q;
  assign weekday_number_o = out_wd_q;
  assign ordinal_day_o    = out_ord_q;
  assign status_o         = out_status_q;

  // ---------------------------------------------------------------- checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&flow.vld)))
    else $error("input stalled while the pipeline has room");

  a_reject_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (out_day_number_o == '0 && out_year_o == '0 &&
      out_month_o == '0 && out_dom_o == '0 && weekday_number_o == '0 &&
      ordinal_day_o == '0))
    else $error("rejected transaction carries nonzero fields");

  a_date_fields_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |-> (out_month_o >= 4'd1 && out_month_o <= 4'd12 &&
      weekday_number_o <= 3'd6 && ordinal_day_o >= 9'd1 && ordinal_day_o <= 9'd366))
    else $error("converted date field out of range");

  a_jd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !status_o) |-> (out_day_number_o >= cjd_pkg::JdMin &&
      out_day_number_o <= cjd_pkg::JdMax && out_year_o != '0))
    else $error("accepted transaction produced day number out of range");

endmodule
